@@ rtl/rme_pkg.sv @@
// Shared types, constants and functions for the rotation matrix to Euler converter.
`timescale 1ns / 1ps
package rme_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int IN_W        = 16;
   localparam int PRE_SHIFT   = 20;
   localparam int ITERS       = 24;
   localparam int ANG_BITS    = 24;
   localparam int OUT_BITS    = 13;
   localparam int CW          = 40;   // CORDIC x/y datapath width
   localparam int ZW          = 28;   // CORDIC angle width
   localparam int ANGLE_LIMIT = 25736;
   localparam int PITCH_LIMIT = 12868;
   localparam int THR_W       = 15;
   localparam int SQ_W        = 32;   // r00^2 + r10^2 width
   localparam int ROOT_W      = 16;
   localparam int SQ_STEPS    = ROOT_W;
   localparam int IDX_W       = 5;
   localparam int PIPE_DEPTH  = SQ_STEPS + 1 + ITERS;

   typedef logic signed [CW-1:0] cval_type;
   typedef logic signed [ZW-1:0] zval_type;

   typedef struct packed {
      cval_type x;
      cval_type y;
      zval_type z;
      logic     zero;
   } cordic_type;

   typedef struct packed {
      logic signed [IN_W-1:0] r10;
      logic signed [IN_W-1:0] r00;
      logic signed [IN_W-1:0] r20;
      logic signed [IN_W-1:0] r21;
      logic signed [IN_W-1:0] r22;
      logic signed [IN_W-1:0] r12;
      logic signed [IN_W-1:0] r11;
      logic [THR_W-1:0]       thr;
   } entries_type;

   typedef struct packed {
      logic [SQ_W+1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_type;

   function automatic zval_type atan_q24(input logic [IDX_W-1:0] i);
      case (i)
         5'd0:  atan_q24 = 28'sd13176795;
         5'd1:  atan_q24 = 28'sd7778716;
         5'd2:  atan_q24 = 28'sd4110060;
         5'd3:  atan_q24 = 28'sd2086331;
         5'd4:  atan_q24 = 28'sd1047214;
         5'd5:  atan_q24 = 28'sd524117;
         5'd6:  atan_q24 = 28'sd262123;
         5'd7:  atan_q24 = 28'sd131069;
         default: atan_q24 = zval_type'(28'sd1 <<< (5'd24 - i));
      endcase
   endfunction

   // Prepare vector: pre-shift and quadrant fold.
   function automatic cordic_type cordic_init(input logic signed [IN_W:0] y,
                                              input logic signed [IN_W:0] x);
      cordic_type c;
      cval_type   xs;
      cval_type   ys;
      xs = cval_type'(x) <<< PRE_SHIFT;
      ys = cval_type'(y) <<< PRE_SHIFT;
      c.zero = (x == '0) && (y == '0);
      c.z = '0;
      c.x = xs;
      c.y = ys;
      if (xs < 0) begin
         if (ys >= 0) begin
            c.x = ys; c.y = -xs; c.z = zval_type'(2 * atan_q24('0));
         end else begin
            c.x = -ys; c.y = xs; c.z = zval_type'(-2 * atan_q24('0));
         end
      end
      return c;
   endfunction

   function automatic logic signed [IN_W-1:0] cordic_out(input cordic_type c,
                                                          input int limit);
      zval_type r;
      r = (c.z + zval_type'(1 <<< (ANG_BITS - OUT_BITS - 1))) >>> (ANG_BITS - OUT_BITS);
      if (c.zero) r = '0;
      else if (r > zval_type'(limit)) r = zval_type'(limit);
      else if (r < -zval_type'(limit)) r = -zval_type'(limit);
      return r[IN_W-1:0];
   endfunction

endpackage

@@ rtl/rme_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation stage.
`timescale 1ns / 1ps
module rme_cordic_cell (
   input  logic                               clock,
   input  logic                               en,
   input  logic [rme_pkg::IDX_W-1:0]          idx,
   input  rme_pkg::cordic_type                d_in,
   output rme_pkg::cordic_type                d_out
);
   rme_pkg::cordic_type q_ff;
   rme_pkg::cordic_type q_in;
   rme_pkg::cval_type   xs;
   rme_pkg::cval_type   ys;

   always_comb begin
      xs = d_in.x >>> idx;
      ys = d_in.y >>> idx;
      q_in = d_in;
      if (d_in.y > 0) begin
         q_in.x = d_in.x + ys;
         q_in.y = d_in.y - xs;
         q_in.z = d_in.z + rme_pkg::atan_q24(idx);
      end else begin
         q_in.x = d_in.x - ys;
         q_in.y = d_in.y + xs;
         q_in.z = d_in.z - rme_pkg::atan_q24(idx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;
endmodule

@@ rtl/rme_sqrt_cell.sv @@
// One restoring square-root step, carrying the matrix entries alongside.
`timescale 1ns / 1ps
module rme_sqrt_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [rme_pkg::IDX_W-1:0]     idx,
   input  rme_pkg::sqrt_type             s_in,
   input  rme_pkg::entries_type          e_in,
   output rme_pkg::sqrt_type             s_out,
   output rme_pkg::entries_type          e_out
);
   rme_pkg::sqrt_type    s_ff;
   rme_pkg::sqrt_type    s_in_nx;
   rme_pkg::entries_type e_ff;
   logic [rme_pkg::SQ_W+1:0] trial;
   logic [rme_pkg::SQ_W+1:0] bitv;

   always_comb begin
      bitv = (rme_pkg::SQ_W+2)'(1) << (2 * (rme_pkg::SQ_STEPS - 1 - idx));
      trial = (rme_pkg::SQ_W+2)'(s_in.root) + bitv;
      s_in_nx = s_in;
      if (s_in.rem >= trial) begin
         s_in_nx.rem  = s_in.rem - trial;
         s_in_nx.root = rme_pkg::SQ_W'(((rme_pkg::SQ_W+2)'(s_in.root) >> 1) + bitv);
      end else begin
         s_in_nx.root = s_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in_nx;
         e_ff <= e_in;
      end
   end

   assign s_out = s_ff;
   assign e_out = e_ff;
endmodule

@@ rtl/rotation_matrix_to_euler.sv @@
// Top level: pipelined sqrt chain followed by three CORDIC cell chains.
//
// channel  | dir | handshake           | payload
// req      | in  | req_tvalid/tready   | req_tdata  : r00,r10,r20,r21,r22,r12,r11
// rsp      | out | rsp_tvalid/tready   | rsp_tdata  : roll,pitch,yaw ; rsp_tuser: singular
// csr      | in  | csr_valid/csr_ready | csr_wdata  : singular_threshold
//
// One request per cycle while the pipe is not halted; the pipe is 16 sqrt cells + 1 mux stage
// + 24 CORDIC cells + 1 output register. The whole pipe advances together and halts
// when the output register holds an untaken response. Reset clears valid bits
// and sets the threshold to 1.
`timescale 1ns / 1ps
module rotation_matrix_to_euler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // r00,r10,r20,r21,r22,r12,r11 (16 each) from bit 0
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // roll[15:0], pitch[30:16], yaw[46:31], zero pad
   output logic         rsp_tuser,   // singular
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [14:0]  csr_wdata    // singular_threshold
);
   logic [rme_pkg::THR_W-1:0]      thr_ff;
   logic [rme_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic                           adv;
   logic                           out_vld_ff;
   logic [47:0]                    out_data_ff;
   logic                           out_sing_ff;

   rme_pkg::sqrt_type    sq [rme_pkg::SQ_STEPS+1];
   rme_pkg::entries_type en [rme_pkg::SQ_STEPS+1];
   rme_pkg::cordic_type  cr [rme_pkg::ITERS+1];
   rme_pkg::cordic_type  cp [rme_pkg::ITERS+1];
   rme_pkg::cordic_type  cy [rme_pkg::ITERS+1];
   logic [rme_pkg::ITERS:0] sg_ff;
   logic                    sing_in;
   logic signed [rme_pkg::IN_W-1:0] sq_root;
   logic signed [rme_pkg::IN_W-1:0] e11, e12, e20, e00;
   logic signed [31:0]  p00, p10;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= rme_pkg::THR_W'(1);
      else if (csr_valid) thr_ff <= csr_wdata;
   end

   always_comb begin
      e00 = req_tdata[15:0];
      e11 = req_tdata[111:96];
      p00 = e00 * e00;
      p10 = $signed(req_tdata[31:16]) * $signed(req_tdata[31:16]);
      sq[0].rem  = (rme_pkg::SQ_W+2)'($unsigned(p00)) + (rme_pkg::SQ_W+2)'($unsigned(p10));
      sq[0].root = '0;
      en[0].r00 = req_tdata[15:0];
      en[0].r10 = req_tdata[31:16];
      en[0].r20 = req_tdata[47:32];
      en[0].r21 = req_tdata[63:48];
      en[0].r22 = req_tdata[79:64];
      en[0].r12 = req_tdata[95:80];
      en[0].r11 = e11;
      en[0].thr = thr_ff;
   end

   for (genvar g = 0; g < rme_pkg::SQ_STEPS; g++) begin : g_sq
      rme_sqrt_cell u_cell (
         .clock(clock), .en(adv), .idx(rme_pkg::IDX_W'(g)),
         .s_in(sq[g]), .e_in(en[g]), .s_out(sq[g+1]), .e_out(en[g+1])
      );
   end

   always_comb begin
      sq_root = $signed(sq[rme_pkg::SQ_STEPS].root[rme_pkg::ROOT_W-1:0]);
      e12 = en[rme_pkg::SQ_STEPS].r12;
      e20 = en[rme_pkg::SQ_STEPS].r20;
      sing_in = sq[rme_pkg::SQ_STEPS].root[rme_pkg::ROOT_W-1:0]
                < {1'b0, en[rme_pkg::SQ_STEPS].thr};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp[0] <= rme_pkg::cordic_init(-(17'(e20)), {1'b0, sq_root});
         if (sing_in)
            cr[0] <= rme_pkg::cordic_init(-(17'(e12)), 17'(en[rme_pkg::SQ_STEPS].r11));
         else
            cr[0] <= rme_pkg::cordic_init(17'(en[rme_pkg::SQ_STEPS].r21),
                                          17'(en[rme_pkg::SQ_STEPS].r22));
         cy[0] <= rme_pkg::cordic_init(17'(en[rme_pkg::SQ_STEPS].r10),
                                       17'(en[rme_pkg::SQ_STEPS].r00));
         sg_ff <= {sg_ff[rme_pkg::ITERS-1:0], sing_in};
      end
   end

   for (genvar g = 0; g < rme_pkg::ITERS; g++) begin : g_cr
      rme_cordic_cell u_r (.clock(clock), .en(adv), .idx(rme_pkg::IDX_W'(g)),
                           .d_in(cr[g]), .d_out(cr[g+1]));
      rme_cordic_cell u_p (.clock(clock), .en(adv), .idx(rme_pkg::IDX_W'(g)),
                           .d_in(cp[g]), .d_out(cp[g+1]));
      rme_cordic_cell u_y (.clock(clock), .en(adv), .idx(rme_pkg::IDX_W'(g)),
                           .d_in(cy[g]), .d_out(cy[g+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[rme_pkg::PIPE_DEPTH-2:0], req_tvalid};
         out_vld_ff <= vld_ff[rme_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_sing_ff <= sg_ff[rme_pkg::ITERS];
         out_data_ff[15:0]  <= rme_pkg::cordic_out(cr[rme_pkg::ITERS], rme_pkg::ANGLE_LIMIT);
         out_data_ff[30:16] <= 15'(rme_pkg::cordic_out(cp[rme_pkg::ITERS],
                                                       rme_pkg::PITCH_LIMIT));
         out_data_ff[46:31] <= sg_ff[rme_pkg::ITERS] ? '0 :
                               rme_pkg::cordic_out(cy[rme_pkg::ITERS], rme_pkg::ANGLE_LIMIT);
         out_data_ff[47]    <= 1'b0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sing_ff;
endmodule

@@ tb/tb_rotation_matrix_to_euler.sv @@
// Testbench for the rotation matrix to Euler converter: directed table, random matrices, predictor.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler;

   localparam int LATENCY   = 42;
   localparam int WATCHDOG  = 20000;
   localparam int N_RANDOM  = 1950;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               singular;
   } angles_type;

   typedef struct {
      logic [15:0] m [7];   // r00,r10,r20,r21,r22,r12,r11
      bit          known;
      angles_type  ang;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [14:0]  csr_wdata;

   angles_type expected_angles [$];
   int       errors;
   int       shown;
   int       idle_cycles;
   int       send_gap;
   int       recv_gap;
   logic [14:0] threshold;
   longint   atan_tab [24];

   rotation_matrix_to_euler uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_atan2(longint y, longint x, longint limit);
      longint z, t, xs, ys, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (64'sd1 << 20);
      y = y * (64'sd1 << 20);
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 2 * atan_tab[0];
         end else begin
            t = x; x = -y; y = t; z = -2 * atan_tab[0];
         end
      end
      for (int i = 0; i < 24; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += atan_tab[i];
         end else begin
            x -= ys; y += xs; z -= atan_tab[i];
         end
      end
      r = shr_floor(z + (64'sd1 << 10), 11);
      if (r > limit) r = limit;
      if (r < -limit) r = -limit;
      return r;
   endfunction

   function automatic longint floor_sqrt(longint n);
      longint root, b;
      root = 0;
      b = 64'sd1 << 40;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic angles_type euler_angles(logic [15:0] m [7]);
      angles_type a;
      longint r00, r10, r20, r21, r22, r12, r11, sy;
      r00 = longint'($signed(m[0])); r10 = longint'($signed(m[1]));
      r20 = longint'($signed(m[2])); r21 = longint'($signed(m[3]));
      r22 = longint'($signed(m[4])); r12 = longint'($signed(m[5]));
      r11 = longint'($signed(m[6]));
      sy = floor_sqrt(r00 * r00 + r10 * r10);
      a.singular = sy < longint'(threshold);
      a.pitch = 15'(cordic_atan2(-r20, sy, 12868));
      if (!a.singular) begin
         a.roll = 16'(cordic_atan2(r21, r22, 25736));
         a.yaw  = 16'(cordic_atan2(r10, r00, 25736));
      end else begin
         a.roll = 16'(cordic_atan2(-r12, r11, 25736));
         a.yaw  = '0;
      end
      return a;
   endfunction

   function automatic logic [15:0] entry_value();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8)) - 16'd4;
         2: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic send_matrix(logic [15:0] m [7], bit known, angles_type ang);
      angles_type pred;
      pred = euler_angles(m);
      if (known) pred = ang;
      if (send_gap > 0 && $urandom_range(0, 99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (send_gap > 0 && $urandom_range(0, 99) < send_gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_angles.insert(expected_angles.size(), pred);
   endtask

   task automatic write_threshold(logic [14:0] value);
      req_tvalid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   always @(posedge clock) begin
      angles_type e;
      logic signed [15:0] g_roll, g_yaw;
      logic signed [14:0] g_pitch;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_gap > 0 && $urandom_range(0, 99) < recv_gap);
         if (rsp_tvalid && rsp_tready) begin
            g_roll  = rsp_tdata[15:0];
            g_pitch = rsp_tdata[30:16];
            g_yaw   = rsp_tdata[46:31];
            if (expected_angles.size() == 0) begin
               errors++;
               if (shown < 10) begin
                  shown++;
                  $display("unexpected response %h user %b", rsp_tdata, rsp_tuser);
               end
            end else begin
               e = expected_angles.pop_front();
               if (g_roll !== e.roll || g_pitch !== e.pitch || g_yaw !== e.yaw
                   || rsp_tuser !== e.singular || rsp_tdata[47] !== 1'b0) begin
                  errors++;
                  if (shown < 10) begin
                     shown++;
                     $display("mismatch exp roll %0d pitch %0d yaw %0d sing %b",
                              e.roll, e.pitch, e.yaw, e.singular);
                     $display("         got roll %0d pitch %0d yaw %0d sing %b",
                              g_roll, g_pitch, g_yaw, rsp_tuser);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      row_type     directed [$];
      row_type     r;
      logic [15:0] m [7];
      angles_type  none;
      logic [14:0] thr_steps [4];
      int          per_phase;
      atan_tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                   65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
      none = '{default: '0};
      errors = 0; shown = 0;
      send_gap = 9; recv_gap = 66;
      threshold = 15'd1;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_valid = 1'b0; csr_wdata = '0;
      rsp_tready = 1'b0;

      // identity, all zero, flips, extremes, near singular, gimbal lock
      r.known = 1'b0;
      r.m = '{16384, 0, 0, 0, 16384, 0, 16384}; r.known = 1'b1;
      r.ang = '{roll: 0, pitch: 0, yaw: 0, singular: 0};
      directed.insert(directed.size(), r);
      r.m = '{0, 0, 0, 0, 0, 0, 0};
      r.ang = '{roll: 0, pitch: 0, yaw: 0, singular: 1};
      directed.insert(directed.size(), r);
      r.known = 1'b0;
      r.m = '{-16384, 0, 0, 0, -16384, 0, -16384}; directed.insert(directed.size(), r);
      r.m = '{0, 16384, 0, 16384, 0, 0, 0}; directed.insert(directed.size(), r);
      r.m = '{0, -16384, 0, -16384, 0, 0, 0}; directed.insert(directed.size(), r);
      r.m = '{0, 0, 16384, 0, 0, 16384, 16384}; directed.insert(directed.size(), r);
      r.m = '{0, 0, -16384, 0, 0, -16384, -16384}; directed.insert(directed.size(), r);
      r.m = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      directed.insert(directed.size(), r);
      r.m = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
      directed.insert(directed.size(), r);
      r.m = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
      directed.insert(directed.size(), r);
      r.m = '{1, 0, 5, -3, -7, 9, -2}; directed.insert(directed.size(), r);
      r.m = '{-1, 1, -16384, 100, -100, -1, 1}; directed.insert(directed.size(), r);
      r.m = '{11585, 11585, 0, 0, 16384, 0, 16384}; directed.insert(directed.size(), r);
      r.m = '{-11585, -11585, 16384, 0, -16384, 0, -16384};
      directed.insert(directed.size(), r);
      r.m = '{0, 0, 0, -1, 0, 0, -1}; directed.insert(directed.size(), r);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_matrix(directed[i].m, directed[i].known, directed[i].ang);

      thr_steps = '{15'd0, 15'd16384, 15'd200, 15'($urandom_range(1, 16384))};
      per_phase = N_RANDOM / 4;
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thr_steps[ph]);
         if (ph == 2) begin
            send_gap = 66; recv_gap = 9;
         end else if (ph == 3) begin
            send_gap = 0; recv_gap = 0;
         end
         for (int n = 0; n < per_phase; n++) begin
            foreach (m[k]) m[k] = entry_value();
            if ($urandom_range(0, 5) == 0) begin
               m[0] = 16'($urandom_range(0, 400)) - 16'd200;
               m[1] = 16'($urandom_range(0, 400)) - 16'd200;
            end
            send_matrix(m, 1'b0, none);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ rotation_matrix_to_euler.f @@
rtl/rme_pkg.sv
rtl/rme_cordic_cell.sv
rtl/rme_sqrt_cell.sv
rtl/rotation_matrix_to_euler.sv
tb/tb_rotation_matrix_to_euler.sv
